// ===== rtl/soa_pkg.sv =====
// types and constants shared by the slot allocator modules
`timescale 1ns / 1ps

package soa_pkg;

    localparam int IDX_W  = 13;
    localparam int CELL_W = 32;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic [1:0] opcode;
        logic [8:0] slot;
    } t_in_item;

    typedef struct packed {
        logic [8:0] granted_slot;
        logic       failed;
        logic [9:0] list_position;
        logic       list_overflow;
        logic [8:0] high_water;
    } t_out_item;

    typedef struct packed {
        logic free_found;
        t_idx free_idx;
        logic hi_found;
        t_idx hi_idx;
    } t_scan;

    typedef struct packed {
        logic alloc;
        t_idx grant_idx;
        logic list_wr;
        t_idx pos;
        logic free;
        t_idx free_idx;
        logic clr;
    } t_cmd;

endpackage

// ===== rtl/soa_cell.sv =====
// one cell of the slot map and order list chain, with its part of the scan
`timescale 1ns / 1ps

module soa_cell #(
    parameter int SLOTS    = 512,
    parameter int CELL_IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  soa_pkg::t_cmd  i_cmd,
    input  soa_pkg::t_scan i_scan,
    output soa_pkg::t_scan o_scan
);

    localparam int W    = soa_pkg::CELL_W;
    localparam int SW   = $clog2(SLOTS);
    localparam int BASE = CELL_IDX * W;

    logic [W-1:0]  r_used;
    logic [W-1:0]  r_valid;
    logic [SW-1:0] r_slot_q [W];
    soa_pkg::t_scan r_scan;
    soa_pkg::t_scan n_scan;

    always_comb begin
        logic          loc_free;
        soa_pkg::t_idx loc_free_idx;
        logic          loc_hi;
        soa_pkg::t_idx loc_hi_idx;
        loc_free     = 1'b0;
        loc_free_idx = '0;
        loc_hi       = 1'b0;
        loc_hi_idx   = '0;
        for (int j = W - 1; j >= 0; j--) begin
            if ((BASE + j < SLOTS) && !r_used[j]) begin
                loc_free     = 1'b1;
                loc_free_idx = soa_pkg::t_idx'(BASE + j);
            end
        end
        for (int j = 0; j < W; j++) begin
            if (r_valid[j]) begin
                loc_hi     = 1'b1;
                loc_hi_idx = soa_pkg::t_idx'(BASE + j);
            end
        end
        n_scan.free_found = i_scan.free_found | loc_free;
        n_scan.free_idx   = i_scan.free_found ? i_scan.free_idx : loc_free_idx;
        n_scan.hi_found   = i_scan.hi_found | loc_hi;
        n_scan.hi_idx     = loc_hi ? loc_hi_idx : i_scan.hi_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan  <= '0;
            r_used  <= '0;
            r_valid <= '0;
        end else begin
            r_scan <= n_scan;
            if (i_cmd.clr) begin
                r_used  <= '0;
                r_valid <= '0;
            end else begin
                for (int j = 0; j < W; j++) begin
                    if (i_cmd.alloc && i_cmd.grant_idx == soa_pkg::t_idx'(BASE + j)) begin
                        r_used[j] <= 1'b1;
                    end
                    if (i_cmd.alloc && i_cmd.list_wr
                            && i_cmd.pos == soa_pkg::t_idx'(BASE + j)) begin
                        r_valid[j] <= 1'b1;
                    end
                    if (i_cmd.free && i_cmd.free_idx == soa_pkg::t_idx'(BASE + j)) begin
                        r_used[j] <= 1'b0;
                    end
                    if (i_cmd.free && r_valid[j]
                            && soa_pkg::t_idx'(r_slot_q[j]) == i_cmd.free_idx) begin
                        r_valid[j] <= 1'b0;
                    end
                end
            end
        end
    end

    // list payload, only read while the entry is valid
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < W; j++) begin
            if (i_cmd.alloc && i_cmd.list_wr && i_cmd.pos == soa_pkg::t_idx'(BASE + j)) begin
                r_slot_q[j] <= i_cmd.grant_idx[SW-1:0];
            end
        end
    end

    assign o_scan = r_scan;

endmodule

// ===== rtl/slot_allocator_with_order_list_top.sv =====
// slot allocator with order list: cell chain, sequencer and output register
// free and clear: committed in the scan state once the output register is free
// allocate: committed once the scan has also run through all NC = ceil((SLOTS + 1) / 32)
//   cells of the scan chain; the result is registered at commit
// one transaction in flight; the next is taken while a result waits to be read
// synchronous reset clears slot map, list valid bits and high-water mark at once
`timescale 1ns / 1ps

module slot_allocator_with_order_list_top #(
    parameter int SLOTS = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  soa_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output soa_pkg::t_out_item o_out_data
);

    localparam int SW = $clog2(SLOTS);
    localparam int NC = (SLOTS + soa_pkg::CELL_W) / soa_pkg::CELL_W;
    localparam int CW = $clog2(NC + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state             r_state;
    t_state             n_state;
    soa_pkg::t_in_item  r_op;
    logic [CW-1:0]      r_cnt;
    logic [SW-1:0]      r_high;
    logic [SW-1:0]      n_high;
    logic               r_out_valid;
    soa_pkg::t_out_item r_out;
    soa_pkg::t_out_item n_out;
    soa_pkg::t_cmd      w_cmd;
    soa_pkg::t_scan     w_scan [NC];
    soa_pkg::t_scan     w_fin;
    soa_pkg::t_idx      w_pos;
    soa_pkg::t_idx      w_high_ext;
    logic               w_alloc;
    logic               w_free;
    logic               w_clear;
    logic               w_grant;
    logic               w_ovf;
    logic               w_done;
    logic               w_commit;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        if (k == 0) begin : g_head
            soa_cell #(.SLOTS(SLOTS), .CELL_IDX(k)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_scan  ('0),
                .o_scan  (w_scan[k])
            );
        end else begin : g_body
            soa_cell #(.SLOTS(SLOTS), .CELL_IDX(k)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_scan  (w_scan[k-1]),
                .o_scan  (w_scan[k])
            );
        end
    end

    assign w_fin    = w_scan[NC-1];
    assign w_alloc  = (r_op.opcode == soa_pkg::OP_ALLOC);
    assign w_free   = (r_op.opcode == soa_pkg::OP_FREE);
    assign w_clear  = (r_op.opcode == soa_pkg::OP_CLEAR);
    assign w_grant  = w_alloc && w_fin.free_found;
    assign w_ovf    = w_fin.hi_found && (w_fin.hi_idx == soa_pkg::t_idx'(SLOTS));
    assign w_pos    = w_fin.hi_found ? w_fin.hi_idx + soa_pkg::t_idx'(1) : '0;
    assign w_done   = !w_alloc || (r_cnt == CW'(NC));
    assign w_commit = (r_state == ST_SCAN) && w_done && (!r_out_valid || i_out_ready);

    always_comb begin
        w_cmd.alloc     = w_commit && w_grant;
        w_cmd.grant_idx = w_fin.free_idx;
        w_cmd.list_wr   = !w_ovf;
        w_cmd.pos       = w_pos;
        w_cmd.free      = w_commit && w_free
                          && (soa_pkg::t_idx'(r_op.slot) < soa_pkg::t_idx'(SLOTS));
        w_cmd.free_idx  = soa_pkg::t_idx'(r_op.slot);
        w_cmd.clr       = w_commit && w_clear;
    end

    always_comb begin
        n_high = r_high;
        if (w_clear) begin
            n_high = '0;
        end else if (w_grant && w_fin.free_idx > soa_pkg::t_idx'(r_high)) begin
            n_high = w_fin.free_idx[SW-1:0];
        end
        w_high_ext            = soa_pkg::t_idx'(n_high);
        n_out.granted_slot    = w_grant ? w_fin.free_idx[8:0] : '0;
        n_out.failed          = w_alloc && !w_fin.free_found;
        n_out.list_position   = (w_grant && !w_ovf) ? w_pos[9:0] : '0;
        n_out.list_overflow   = w_grant && w_ovf;
        n_out.high_water      = w_high_ext[8:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_high      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_cnt <= '0;
            end else if (r_cnt != CW'(NC)) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (w_commit) begin
                r_high      <= n_high;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op <= i_in_data;
        end
        if (w_commit) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/soa_checker.sv =====
// port level checks for the slot allocator, bound to the top level
`timescale 1ns / 1ps

module soa_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input soa_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input soa_pkg::t_out_item o_out_data
);

    // no result straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a waiting input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=> (i_in_valid && $stable(i_in_data)))
        else $error("input dropped or changed while stalled");

    // a failed allocate grants nothing
    a_fail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.failed) |->
        (o_out_data.granted_slot == 9'd0 && o_out_data.list_position == 10'd0
         && !o_out_data.list_overflow))
        else $error("failed transaction carries a grant");

    // a dropped list write reports no position
    a_ovf_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.list_overflow) |->
        (o_out_data.list_position == 10'd0 && !o_out_data.failed))
        else $error("overflow with list position");

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result dropped or changed while stalled");

endmodule

bind slot_allocator_with_order_list_top soa_checker u_soa_checker (.*);
